/* sv/yrp_pkg.sv */
// ----------------------------------------------------------------------------
// yrp_pkg: shared definitions for the YUV chroma resample pipeline
// Defaults, register indexes, controller states, fixed-point coefficient
// helper and the divider status bundle.
// ----------------------------------------------------------------------------
package yrp_pkg;

  localparam int MAX_FACTOR_DEF    = 8;
  localparam int FRACTION_BITS_DEF = 10;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 9;
  localparam int DIV_W             = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_FACTOR    = 3'd0,
    REG_CB_FACTOR      = 3'd1,
    REG_CR_FACTOR      = 3'd2,
    REG_EDGE_THRESHOLD = 3'd3,
    REG_CLAMP_ENABLE   = 3'd4,
    REG_QUANT_LEVELS   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD,
    ST_URD,
    ST_UWR,
    ST_APPEND,
    ST_ERD,
    ST_ECHK,
    ST_BACK,
    ST_STEP,
    ST_QDIV,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Coefficient m/1000 scaled by 2^fb, rounded half away from zero.
  function automatic int fixp(input int m, input int fb);
    int res;
    if (m >= 0) begin
      res = (m * (1 << fb) + 500) / 1000;
    end else begin
      res = -(((-m) * (1 << fb) + 500) / 1000);
    end
    return res;
  endfunction

endpackage

/* sv/yrp_rgb2yuv.sv */
// ----------------------------------------------------------------------------
// yrp_rgb2yuv: forward color conversion
// Two-stage pipeline: registered products, then registered channel sums.
// ----------------------------------------------------------------------------
module yrp_rgb2yuv #(
  parameter int FRACTION_BITS = yrp_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic signed [FRACTION_BITS+9:0] y,
  output logic signed [FRACTION_BITS+9:0] u,
  output logic signed [FRACTION_BITS+9:0] v
);
  import yrp_pkg::*;

  localparam int YW = FRACTION_BITS + 10;
  localparam logic signed [YW-1:0] K_YR = YW'(fixp(299, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_YG = YW'(fixp(587, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_YB = YW'(fixp(114, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_UR = YW'(fixp(-147, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_UG = YW'(fixp(-289, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_UB = YW'(fixp(436, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_VR = YW'(fixp(615, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_VG = YW'(fixp(-515, FRACTION_BITS));
  localparam logic signed [YW-1:0] K_VB = YW'(fixp(-100, FRACTION_BITS));

  logic signed [YW-1:0] rs, gs, bs;
  logic signed [YW-1:0] p_yr, p_yg, p_yb, p_ur, p_ug, p_ub, p_vr, p_vg, p_vb;

  assign rs = $signed({{(YW-8){1'b0}}, red});
  assign gs = $signed({{(YW-8){1'b0}}, green});
  assign bs = $signed({{(YW-8){1'b0}}, blue});

  always_ff @(posedge clk) begin
    p_yr <= rs * K_YR;
    p_yg <= gs * K_YG;
    p_yb <= bs * K_YB;
    p_ur <= rs * K_UR;
    p_ug <= gs * K_UG;
    p_ub <= bs * K_UB;
    p_vr <= rs * K_VR;
    p_vg <= gs * K_VG;
    p_vb <= bs * K_VB;
  end

  always_ff @(posedge clk) begin
    y <= p_yr + p_yg + p_yb;
    u <= p_ur + p_ug + p_ub;
    v <= p_vr + p_vg + p_vb;
  end

endmodule

/* sv/yrp_yuv2rgb.sv */
// ----------------------------------------------------------------------------
// yrp_yuv2rgb: inverse color conversion with rounding and range handling
// Three stages: products, sums, then rounding with saturation or wrap.
// ----------------------------------------------------------------------------
module yrp_yuv2rgb #(
  parameter int FRACTION_BITS = yrp_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic signed [FRACTION_BITS+9:0] y,
  input  logic signed [FRACTION_BITS+9:0] u,
  input  logic signed [FRACTION_BITS+9:0] v,
  input  logic                            clamp_en,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue
);
  import yrp_pkg::*;

  localparam int YW = FRACTION_BITS + 10;
  localparam int AW = YW + FRACTION_BITS + 4;
  localparam logic signed [AW-1:0] K_RV = AW'(fixp(1140, FRACTION_BITS));
  localparam logic signed [AW-1:0] K_GU = AW'(fixp(-395, FRACTION_BITS));
  localparam logic signed [AW-1:0] K_GV = AW'(fixp(-581, FRACTION_BITS));
  localparam logic signed [AW-1:0] K_BU = AW'(fixp(2032, FRACTION_BITS));
  localparam logic [AW-1:0] HALF = AW'(1) << (2 * FRACTION_BITS - 1);

  logic signed [AW-1:0] ye, ue, ve;
  logic signed [AW-1:0] p_y, p_rv, p_gu, p_gv, p_bu;
  logic signed [AW-1:0] acc_r, acc_g, acc_b;

  assign ye = AW'(y);
  assign ue = AW'(u);
  assign ve = AW'(v);

  always_ff @(posedge clk) begin
    p_y  <= ye <<< FRACTION_BITS;
    p_rv <= ve * K_RV;
    p_gu <= ue * K_GU;
    p_gv <= ve * K_GV;
    p_bu <= ue * K_BU;
  end

  always_ff @(posedge clk) begin
    acc_r <= p_y + p_rv;
    acc_g <= p_y + p_gu + p_gv;
    acc_b <= p_y + p_bu;
  end

  // Round half away from zero, then saturate or keep the low byte.
  function automatic logic [7:0] finish(input logic signed [AW-1:0] acc, input logic sat);
    logic [AW-1:0]        mag;
    logic [AW-1:0]        t;
    logic signed [AW-1:0] rv;
    logic [7:0]           res;
    mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
    t   = (mag + HALF) >> (2 * FRACTION_BITS);
    rv  = acc[AW-1] ? -$signed(t) : $signed(t);
    if (sat) begin
      if (rv < 0) begin
        res = 8'd0;
      end else if (rv > AW'(255)) begin
        res = 8'd255;
      end else begin
        res = rv[7:0];
      end
    end else begin
      res = rv[7:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    red   <= finish(acc_r, clamp_en);
    green <= finish(acc_g, clamp_en);
    blue  <= finish(acc_b, clamp_en);
  end

endmodule

/* sv/yrp_divider.sv */
// ----------------------------------------------------------------------------
// yrp_divider: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module yrp_divider #(
  parameter int W = yrp_pkg::DIV_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output logic [W-1:0]         quotient,
  output yrp_pkg::div_stat_t   status
);
  import yrp_pkg::*;

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    rem, quo, dvs;
  logic [W:0]      trial;
  logic [CNTW-1:0] cnt;
  logic            busy, done;

  assign trial    = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;
  assign status   = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/yuv_chroma_resample_pipeline_core.sv */
// ----------------------------------------------------------------------------
// yuv_chroma_resample_pipeline_core: RGB to YUV, subsample, refill, back to RGB
// Buffers pixels in a small synchronous memory until every channel of a
// pixel is resolved, then rebuilds and optionally quantizes each pixel.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request passes through acceptance, the
// forward conversion, the append and the first read of the oldest pending entry;
// before the append, each pixel already waiting in the pending memory is read,
// refilled and written back in turn. When the oldest entry is still unresolved,
// a check state finds this before the next request can be taken. Every pixel
// that becomes resolved then passes through the check, the inverse conversion
// pipeline, the output state and the read of the next entry. Quantization with
// a step adds a pass of the bit-serial divider per pixel, plus one more pass
// once after quant_levels is written, when the quantizer step is derived.
// Result delivery waits for out_ready; no new request is taken until all
// resolved pixels have been delivered. The pending memory holds MAX_FACTOR
// entries, enough for the largest factor, and needs no clearing after reset.
// ----------------------------------------------------------------------------
module yuv_chroma_resample_pipeline_core #(
  parameter int MAX_FACTOR    = yrp_pkg::MAX_FACTOR_DEF,
  parameter int FRACTION_BITS = yrp_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     red_in,
  input  logic [7:0]                     green_in,
  input  logic [7:0]                     blue_in,
  input  logic                           end_of_image,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     red_out,
  output logic [7:0]                     green_out,
  output logic [7:0]                     blue_out,
  output logic                           last_out,
  input  logic                           cfg_write,
  input  logic [yrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import yrp_pkg::*;

  localparam int YW = FRACTION_BITS + 10;
  localparam int CW = $clog2(MAX_FACTOR + 1);
  localparam int PW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  // One pending entry: unresolved flags and the three channel values.
  typedef struct packed {
    logic [2:0]         open;
    logic [2:0][YW-1:0] val;
  } pend_t;

  // Configuration registers.
  logic [3:0] luma_factor, cb_factor, cr_factor;
  logic [8:0] edge_threshold, quant_levels;
  logic       clamp_enable;

  // Control state.
  ctl_state_t    state, state_next;
  logic [PW-1:0] head;
  logic [CW-1:0] pend_count;
  logic [CW-1:0] k;
  logic [PW-1:0] phase [3];
  logic [1:0]    wcnt;
  logic          step_ok;
  logic [2:0]    keep;
  logic          eoi_q;

  // Payload.
  logic [7:0]           r_q, g_q, b_q;
  logic signed [YW-1:0] cur [3];
  logic [YW-1:0]        kept [3];
  logic [8:0]           step;

  // Pending memory.
  pend_t         mem [MAX_FACTOR];
  pend_t         mem_rdata, mem_wdata;
  logic          mem_we;
  logic [PW-1:0] mem_waddr, mem_raddr;

  // Converters and dividers.
  logic [7:0]       x_r, x_g, x_b;
  logic             div_start, div_step_sel;
  logic [DIV_W-1:0] dvd [3];
  logic [DIV_W-1:0] dvs [3];
  logic [DIV_W-1:0] quo [3];
  div_stat_t        dstat [3];

  // Quantizer decode.
  logic       q_bypass, q_zero;
  logic [7:0] q_n;

  logic [PW-1:0] slot_k, slot_tail, head_inc;
  pend_t         upd_entry, new_entry;

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_FACTOR)) begin
      s = s - (CW+1)'(MAX_FACTOR);
    end
    return PW'(s);
  endfunction

  function automatic logic [4:0] eff_factor(input logic [3:0] f);
    logic [4:0] res;
    if (f == 4'd0) begin
      res = 5'd1;
    end else if ({1'b0, f} > 5'(MAX_FACTOR)) begin
      res = 5'(MAX_FACTOR);
    end else begin
      res = {1'b0, f};
    end
    return res;
  endfunction

  // Average of left and right when they are close, else the left value.
  function automatic logic [YW-1:0] fill(input logic signed [YW-1:0] l,
                                        input logic signed [YW-1:0] r,
                                        input logic [8:0] thr);
    logic signed [YW:0] d, s;
    logic [YW:0]        ad;
    logic [YW-1:0]      res;
    d  = (YW+1)'(l) - (YW+1)'(r);
    ad = d[YW] ? (YW+1)'(-d) : (YW+1)'(d);
    s  = (YW+1)'(l) + (YW+1)'(r);
    if (ad > (YW+1)'({thr, {FRACTION_BITS{1'b0}}})) begin
      res = l;
    end else begin
      res = YW'(s >>> 1);
    end
    return res;
  endfunction

  assign slot_k    = wrap(head, k);
  assign slot_tail = wrap(head, pend_count);
  assign head_inc  = wrap(head, CW'(1));

  yrp_rgb2yuv #(.FRACTION_BITS(FRACTION_BITS)) u_fwd (
    .clk   (clk),
    .red   (r_q),
    .green (g_q),
    .blue  (b_q),
    .y     (cur[0]),
    .u     (cur[1]),
    .v     (cur[2])
  );

  yrp_yuv2rgb #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk      (clk),
    .y        ($signed(mem_rdata.val[0])),
    .u        ($signed(mem_rdata.val[1])),
    .v        ($signed(mem_rdata.val[2])),
    .clamp_en (clamp_enable),
    .red      (x_r),
    .green    (x_g),
    .blue     (x_b)
  );

  // Quantizer operands. Lane zero also derives the step when it is stale.
  assign q_bypass = (quant_levels == 9'd0) || (quant_levels > 9'd256);
  assign q_zero   = (quant_levels == 9'd1);
  assign q_n      = 8'(quant_levels - 9'd1);

  always_comb begin
    dvd[0] = div_step_sel ? (DIV_W'(10'd512) + DIV_W'(q_n)) : (DIV_W'({x_r, 1'b0}) + DIV_W'(step));
    dvs[0] = div_step_sel ? DIV_W'({q_n, 1'b0}) : DIV_W'({step, 1'b0});
    dvd[1] = DIV_W'({x_g, 1'b0}) + DIV_W'(step);
    dvs[1] = DIV_W'({step, 1'b0});
    dvd[2] = DIV_W'({x_b, 1'b0}) + DIV_W'(step);
    dvs[2] = DIV_W'({step, 1'b0});
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    yrp_divider #(.W(DIV_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd[i]),
      .divisor  (dvs[i]),
      .quotient (quo[i]),
      .status   (dstat[i])
    );
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Refill of a waiting entry, and the entry built from the new pixel.
  always_comb begin
    upd_entry = mem_rdata;
    new_entry = '0;
    for (int c = 0; c < 3; c++) begin
      if (mem_rdata.open[c]) begin
        if (keep[c]) begin
          upd_entry.val[c]  = fill($signed(kept[c]), cur[c], edge_threshold);
          upd_entry.open[c] = 1'b0;
        end else if (eoi_q) begin
          upd_entry.val[c]  = kept[c];
          upd_entry.open[c] = 1'b0;
        end
      end
      if (keep[c]) begin
        new_entry.val[c] = cur[c];
      end else if (eoi_q) begin
        new_entry.val[c] = kept[c];
      end else begin
        new_entry.open[c] = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_FWD;
        end
      end
      ST_FWD: begin
        if (wcnt == 2'd1) begin
          state_next = (pend_count == '0) ? ST_APPEND : ST_URD;
        end
      end
      ST_URD: state_next = ST_UWR;
      ST_UWR: begin
        state_next = (k + 1'b1 == pend_count) ? ST_APPEND : ST_URD;
      end
      ST_APPEND: state_next = ST_ERD;
      ST_ERD: begin
        state_next = (pend_count == '0) ? ST_IDLE : ST_ECHK;
      end
      ST_ECHK: begin
        state_next = (|mem_rdata.open) ? ST_IDLE : ST_BACK;
      end
      ST_BACK: begin
        if (wcnt == 2'd2) begin
          if (q_bypass || q_zero) begin
            state_next = ST_OUT;
          end else if (step_ok) begin
            state_next = ST_QDIV;
          end else begin
            state_next = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (dstat[0].done) begin
          state_next = ST_BACK;
        end
      end
      ST_QDIV: begin
        if (dstat[0].done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_ERD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = slot_k;
    mem_wdata    = upd_entry;
    mem_raddr    = head;
    div_start    = 1'b0;
    div_step_sel = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_URD:  mem_raddr = slot_k;
      ST_UWR:  mem_we = 1'b1;
      ST_APPEND: begin
        mem_we    = (pend_count < CW'(MAX_FACTOR));
        mem_waddr = slot_tail;
        mem_wdata = new_entry;
      end
      ST_BACK: begin
        if (wcnt == 2'd2 && !q_bypass && !q_zero) begin
          div_start    = 1'b1;
          div_step_sel = !step_ok;
        end
      end
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      pend_count     <= '0;
      k              <= '0;
      wcnt           <= '0;
      step_ok        <= 1'b0;
      keep           <= '0;
      eoi_q          <= 1'b0;
      luma_factor    <= 4'd1;
      cb_factor      <= 4'd1;
      cr_factor      <= 4'd1;
      edge_threshold <= 9'd10;
      clamp_enable   <= 1'b1;
      quant_levels   <= 9'd0;
      for (int c = 0; c < 3; c++) begin
        phase[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_LUMA_FACTOR:    luma_factor <= cfg_data[3:0];
          REG_CB_FACTOR:      cb_factor <= cfg_data[3:0];
          REG_CR_FACTOR:      cr_factor <= cfg_data[3:0];
          REG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
          REG_CLAMP_ENABLE:   clamp_enable <= cfg_data[0];
          REG_QUANT_LEVELS: begin
            quant_levels <= cfg_data;
            step_ok      <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          wcnt <= '0;
          k    <= '0;
          if (in_valid) begin
            eoi_q <= end_of_image;
            for (int c = 0; c < 3; c++) begin
              logic [4:0] p1;
              logic [4:0] ef;
              p1 = 5'(phase[c]) + 5'd1;
              ef = (c == 0) ? eff_factor(luma_factor) :
                   (c == 1) ? eff_factor(cb_factor) : eff_factor(cr_factor);
              keep[c] <= (phase[c] == '0);
              if (end_of_image || p1 >= ef) begin
                phase[c] <= '0;
              end else begin
                phase[c] <= PW'(p1);
              end
            end
          end
        end
        ST_FWD:  wcnt <= wcnt + 2'd1;
        ST_UWR:  k <= k + 1'b1;
        ST_APPEND: begin
          if (pend_count < CW'(MAX_FACTOR)) begin
            pend_count <= pend_count + 1'b1;
          end
        end
        ST_ECHK: wcnt <= '0;
        ST_BACK: begin
          if (wcnt != 2'd2) begin
            wcnt <= wcnt + 2'd1;
          end
        end
        ST_STEP: begin
          if (dstat[0].done) begin
            step_ok <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            head       <= head_inc;
            pend_count <= pend_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      r_q <= red_in;
      g_q <= green_in;
      b_q <= blue_in;
    end
    if (state == ST_APPEND) begin
      for (int c = 0; c < 3; c++) begin
        if (keep[c]) begin
          kept[c] <= cur[c];
        end
      end
    end
    if (state == ST_STEP && dstat[0].done) begin
      step <= 9'(quo[0]);
    end
    if (state == ST_ERD) begin
      last_out <= eoi_q && (pend_count == CW'(1));
    end
    if (state == ST_BACK && wcnt == 2'd2) begin
      if (q_zero) begin
        red_out   <= 8'd0;
        green_out <= 8'd0;
        blue_out  <= 8'd0;
      end else begin
        red_out   <= x_r;
        green_out <= x_g;
        blue_out  <= x_b;
      end
    end
    if (state == ST_QDIV && dstat[0].done) begin
      for (int c = 0; c < 3; c++) begin
        logic [DIV_W+8:0] qp;
        logic [7:0]       qv;
        qp = (DIV_W+9)'(quo[c]) * (DIV_W+9)'(step);
        qv = (qp > (DIV_W+9)'(255)) ? 8'd255 : qp[7:0];
        case (c)
          0:       red_out <= qv;
          1:       green_out <= qv;
          default: blue_out <= qv;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CW'(MAX_FACTOR))
    else $error("pending count above buffer depth");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a result is offered");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> (pend_count == '0))
    else $error("pixels left pending after the final pixel");

  a_eoi_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_image) |=>
      (phase[0] == '0 && phase[1] == '0 && phase[2] == '0))
    else $error("phases not cleared at image end");

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    dstat[0].done |-> (dstat[1].done == dstat[2].done))
    else $error("divider lanes out of step");
`endif

endmodule
